// ----- src/unicode_to_lowercase_defines.svh -----
`ifndef UNICODE_TO_LOWERCASE_DEFINES_SVH
`define UNICODE_TO_LOWERCASE_DEFINES_SVH

// consequent checked later than the antecedent, through a delayed implication
`define UCL_ASSERT_D2(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> ##2 (cons)) else $error("ucl check failed");

// consequent checked in the cycle after the antecedent
`define UCL_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("ucl check failed");

`endif

// ----- src/ucl_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package ucl_pkg;

    localparam int CP_W = 21;

    typedef logic [CP_W-1:0] t_cp;

    typedef enum logic [1:0] {
        SEL_ALL,
        SEL_EVEN,
        SEL_ODD,
        SEL_BIT3
    } t_sel;

    typedef struct packed {
        t_cp  lo;
        t_cp  hi;
        t_sel sel;
        logic fixed;
        t_cp  val;
    } t_rule;

    localparam int RULE_COUNT = 113;

    function automatic t_rule f_add(input t_cp lo, input t_cp hi, input t_sel sel,
                                    input t_cp val);
        t_rule r;
        r.lo    = lo;
        r.hi    = hi;
        r.sel   = sel;
        r.fixed = 1'b0;
        r.val   = val;
        return r;
    endfunction

    function automatic t_rule f_fix(input t_cp lo, input t_cp hi, input t_cp val);
        t_rule r;
        r.lo    = lo;
        r.hi    = hi;
        r.sel   = SEL_ALL;
        r.fixed = 1'b1;
        r.val   = val;
        return r;
    endfunction

    // hi is one past the last point; first match in list order wins
    localparam t_rule RULES [RULE_COUNT] = '{
        f_add(21'h00041, 21'h0005B, SEL_ALL,  21'h20),
        f_add(21'h000C0, 21'h000DF, SEL_ALL,  21'h20),
        f_fix(21'h00178, 21'h00179, 21'h000FF),
        f_add(21'h00100, 21'h00130, SEL_EVEN, 21'h1),
        f_fix(21'h00130, 21'h00131, 21'h00069),
        f_add(21'h00132, 21'h00138, SEL_EVEN, 21'h1),
        f_add(21'h00139, 21'h00149, SEL_ODD,  21'h1),
        f_add(21'h0014A, 21'h00178, SEL_EVEN, 21'h1),
        f_add(21'h00179, 21'h0017F, SEL_ODD,  21'h1),
        f_add(21'h00182, 21'h00186, SEL_EVEN, 21'h1),
        f_add(21'h00187, 21'h00188, SEL_ALL,  21'h1),
        f_add(21'h0018B, 21'h0018C, SEL_ALL,  21'h1),
        f_add(21'h00191, 21'h00192, SEL_ALL,  21'h1),
        f_add(21'h00198, 21'h00199, SEL_ALL,  21'h1),
        f_add(21'h001A0, 21'h001A6, SEL_ODD,  21'h1),
        f_add(21'h001A7, 21'h001A8, SEL_ALL,  21'h1),
        f_add(21'h001AC, 21'h001AD, SEL_ALL,  21'h1),
        f_add(21'h001AF, 21'h001B0, SEL_ALL,  21'h1),
        f_add(21'h001B3, 21'h001B4, SEL_ALL,  21'h1),
        f_add(21'h001B5, 21'h001B6, SEL_ALL,  21'h1),
        f_add(21'h001B8, 21'h001B9, SEL_ALL,  21'h1),
        f_add(21'h001BC, 21'h001BD, SEL_ALL,  21'h1),
        f_add(21'h001C5, 21'h001C6, SEL_ALL,  21'h1),
        f_add(21'h001C8, 21'h001C9, SEL_ALL,  21'h1),
        f_add(21'h001CB, 21'h001CC, SEL_ALL,  21'h1),
        f_add(21'h001CD, 21'h001DD, SEL_ODD,  21'h1),
        f_add(21'h001DE, 21'h001F0, SEL_EVEN, 21'h1),
        f_fix(21'h001F1, 21'h001F2, 21'h001F3),
        f_add(21'h001F4, 21'h001F5, SEL_ALL,  21'h1),
        f_add(21'h001F8, 21'h00220, SEL_EVEN, 21'h1),
        f_fix(21'h00181, 21'h00182, 21'h00253),
        f_fix(21'h00186, 21'h00187, 21'h00254),
        f_fix(21'h0018A, 21'h0018B, 21'h00257),
        f_fix(21'h0018E, 21'h0018F, 21'h00258),
        f_fix(21'h0018F, 21'h00190, 21'h00259),
        f_fix(21'h00190, 21'h00191, 21'h0025B),
        f_fix(21'h00193, 21'h00194, 21'h00260),
        f_fix(21'h00194, 21'h00195, 21'h00263),
        f_fix(21'h00197, 21'h00198, 21'h00268),
        f_fix(21'h00196, 21'h00197, 21'h00269),
        f_fix(21'h0019C, 21'h0019D, 21'h0026F),
        f_fix(21'h0019D, 21'h0019E, 21'h00272),
        f_fix(21'h0019F, 21'h001A0, 21'h00275),
        f_fix(21'h001A9, 21'h001AA, 21'h00283),
        f_fix(21'h001AE, 21'h001AF, 21'h00288),
        f_fix(21'h001B1, 21'h001B2, 21'h0028A),
        f_fix(21'h001B2, 21'h001B3, 21'h0028B),
        f_fix(21'h001B7, 21'h001B8, 21'h00292),
        f_fix(21'h00386, 21'h00387, 21'h003AC),
        f_fix(21'h00388, 21'h00389, 21'h003AD),
        f_fix(21'h00389, 21'h0038A, 21'h003AE),
        f_fix(21'h0038A, 21'h0038B, 21'h003AF),
        f_fix(21'h0038C, 21'h0038D, 21'h003CC),
        f_fix(21'h0038E, 21'h0038F, 21'h003CD),
        f_fix(21'h0038F, 21'h00390, 21'h003CE),
        f_add(21'h00391, 21'h003AC, SEL_ALL,  21'h20),
        f_add(21'h003E2, 21'h003F0, SEL_EVEN, 21'h1),
        f_add(21'h00400, 21'h00410, SEL_ALL,  21'h50),
        f_add(21'h00410, 21'h00430, SEL_ALL,  21'h20),
        f_add(21'h00460, 21'h00482, SEL_EVEN, 21'h1),
        f_add(21'h0048A, 21'h004C0, SEL_EVEN, 21'h1),
        f_add(21'h004C1, 21'h004CF, SEL_ODD,  21'h1),
        f_fix(21'h004C0, 21'h004C1, 21'h004CF),
        f_add(21'h004D0, 21'h00530, SEL_EVEN, 21'h1),
        f_add(21'h00531, 21'h00557, SEL_ALL,  21'h30),
        f_add(21'h010A0, 21'h010D0, SEL_ALL,  21'h30),
        f_add(21'h01E00, 21'h01E96, SEL_EVEN, 21'h1),
        f_add(21'h01EA0, 21'h01F00, SEL_EVEN, 21'h1),
        f_add(21'h01F00, 21'h02000, SEL_BIT3, 21'h1FFFF8),
        f_add(21'h02160, 21'h02170, SEL_ALL,  21'h10),
        f_add(21'h024B6, 21'h024D0, SEL_ALL,  21'h1A),
        f_add(21'h02C00, 21'h02C30, SEL_ALL,  21'h30),
        f_add(21'h02C60, 21'h02C61, SEL_ALL,  21'h1),
        f_add(21'h02C67, 21'h02C68, SEL_ALL,  21'h1),
        f_add(21'h02C69, 21'h02C6A, SEL_ALL,  21'h1),
        f_add(21'h02C6B, 21'h02C6C, SEL_ALL,  21'h1),
        f_add(21'h02C72, 21'h02C73, SEL_ALL,  21'h1),
        f_add(21'h02C75, 21'h02C76, SEL_ALL,  21'h1),
        f_add(21'h02C80, 21'h02CE4, SEL_EVEN, 21'h1),
        f_add(21'h02CEB, 21'h02CEC, SEL_ALL,  21'h1),
        f_add(21'h02CED, 21'h02CEE, SEL_ALL,  21'h1),
        f_add(21'h02CF2, 21'h02CF3, SEL_ALL,  21'h1),
        f_add(21'h0A640, 21'h0A66E, SEL_EVEN, 21'h1),
        f_add(21'h0A680, 21'h0A69C, SEL_EVEN, 21'h1),
        f_add(21'h0A722, 21'h0A730, SEL_EVEN, 21'h1),
        f_add(21'h0A732, 21'h0A770, SEL_EVEN, 21'h1),
        f_add(21'h0A779, 21'h0A77D, SEL_ODD,  21'h1),
        f_add(21'h0A780, 21'h0A788, SEL_EVEN, 21'h1),
        f_add(21'h0A790, 21'h0A794, SEL_EVEN, 21'h1),
        f_add(21'h0A79A, 21'h0A7AA, SEL_EVEN, 21'h1),
        f_add(21'h0A7B6, 21'h0A7C4, SEL_EVEN, 21'h1),
        f_add(21'h0A7C7, 21'h0A7CB, SEL_EVEN, 21'h1),
        f_add(21'h0FF21, 21'h0FF3B, SEL_ALL,  21'h20),
        f_add(21'h10400, 21'h10428, SEL_ALL,  21'h28),
        f_add(21'h104B0, 21'h104D8, SEL_ALL,  21'h28),
        f_add(21'h1D400, 21'h1D41A, SEL_ALL,  21'h1A),
        f_add(21'h1D434, 21'h1D44E, SEL_ALL,  21'h1A),
        f_add(21'h1D468, 21'h1D482, SEL_ALL,  21'h1A),
        f_add(21'h1D49C, 21'h1D4B6, SEL_ALL,  21'h1A),
        f_add(21'h1D4D0, 21'h1D4EA, SEL_ALL,  21'h1A),
        f_add(21'h1D504, 21'h1D51E, SEL_ALL,  21'h1A),
        f_add(21'h1D538, 21'h1D552, SEL_ALL,  21'h1A),
        f_add(21'h1D56C, 21'h1D586, SEL_ALL,  21'h1A),
        f_add(21'h1D5A0, 21'h1D5BA, SEL_ALL,  21'h1A),
        f_add(21'h1D5D4, 21'h1D5EE, SEL_ALL,  21'h1A),
        f_add(21'h1D608, 21'h1D622, SEL_ALL,  21'h1A),
        f_add(21'h1D63C, 21'h1D656, SEL_ALL,  21'h1A),
        f_add(21'h1D670, 21'h1D68A, SEL_ALL,  21'h1A),
        f_add(21'h1D6A8, 21'h1D6C1, SEL_ALL,  21'h1A),
        f_add(21'h1D6E2, 21'h1D6FB, SEL_ALL,  21'h1A),
        f_add(21'h1D71C, 21'h1D735, SEL_ALL,  21'h1A),
        f_add(21'h1D756, 21'h1D76F, SEL_ALL,  21'h1A),
        f_add(21'h1D790, 21'h1D7A9, SEL_ALL,  21'h1A)
    };

    function automatic logic f_hit(input t_rule r, input t_cp cp);
        logic in_rng;
        logic sel_ok;
        in_rng = (cp >= r.lo) && (cp < r.hi);
        case (r.sel)
            SEL_EVEN: sel_ok = ~cp[0];
            SEL_ODD:  sel_ok = cp[0];
            SEL_BIT3: sel_ok = cp[3];
            default:  sel_ok = 1'b1;
        endcase
        return in_rng && sel_ok;
    endfunction

endpackage

`default_nettype wire

// ----- src/unicode_to_lowercase.sv -----
`timescale 1ns / 1ps
`default_nettype none
// channel  | direction | qualifier          | data
// ---------+-----------+--------------------+----------------------
// command  | in        | start && !busy     | i_code_point [20:0]
// result   | out       | o_done (one cycle) | o_lower_code_point [20:0]
//
// one transaction per cycle, busy is never raised
// result strobes after the command passes the input register, then the result register
// compare and select sit between the input and result registers and set the clock period
// synchronous active-low reset clears the valid flags only
// results cannot be stalled; each stands on the ports for one cycle

`include "unicode_to_lowercase_defines.svh"

module unicode_to_lowercase (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                start,
    output logic               busy,
    input  wire  ucl_pkg::t_cp i_code_point,
    output logic               o_done,
    output       ucl_pkg::t_cp o_lower_code_point
);
    import ucl_pkg::*;

    logic r_cp_vld;
    t_cp  r_cp;
    t_cp  w_lower;
    logic r_done;
    t_cp  r_lower;

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cp_vld <= 1'b0;
            r_done   <= 1'b0;
        end else begin
            r_cp_vld <= start && !busy;
            r_done   <= r_cp_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cp    <= i_code_point;
        r_lower <= w_lower;
    end

    ucl_match u_match (
        .i_cp    (r_cp),
        .o_lower (w_lower)
    );

    assign o_done             = r_done;
    assign o_lower_code_point = r_lower;

    `UCL_ASSERT_D2(a_done_latency, start, o_done)
    `UCL_ASSERT_D2(a_no_spurious_done, !start, !o_done)
    `UCL_ASSERT_D2(a_ascii_upper, start && i_code_point >= 21'h41 && i_code_point <= 21'h5A,
        o_lower_code_point == t_cp'($past(i_code_point, 2) + 21'h20))
    `UCL_ASSERT_NEXT(a_out_of_range_kept, r_cp_vld && r_cp > 21'h10FFFF,
        o_done && o_lower_code_point == $past(r_cp))

endmodule

`default_nettype wire

// ----- src/ucl_match.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ucl_match (
    input  wire  ucl_pkg::t_cp i_cp,
    output       ucl_pkg::t_cp o_lower
);
    import ucl_pkg::*;

    logic [RULE_COUNT-1:0] w_hit;

    // all range compares in parallel
    always_comb begin
        for (int i = 0; i < RULE_COUNT; i++) begin
            w_hit[i] = f_hit(RULES[i], i_cp);
        end
    end

    // priority select, lowest rule index wins
    always_comb begin
        o_lower = i_cp;
        for (int i = RULE_COUNT - 1; i >= 0; i--) begin
            if (w_hit[i]) begin
                o_lower = RULES[i].fixed ? RULES[i].val : t_cp'(i_cp + RULES[i].val);
            end
        end
    end

endmodule

`default_nettype wire

// ----- tb/unicode_to_lowercase_tb.sv -----
`timescale 1ns / 1ps

module unicode_to_lowercase_tb;

    import ucl_pkg::*;

    localparam int          RANDOM_CODES = 1250;
    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int unsigned MAX_REPORTS  = 10;
    localparam int unsigned DRAIN_LIMIT  = 50;

    typedef struct {
        t_cp  first;
        t_cp  past;
        t_sel pick;
        bit   absolute;
        t_cp  amount;
    } fold_rule_t;

    class lowercase_scoreboard;
        fold_rule_t  rules[$];
        t_cp         expected_lower[$];
        int unsigned mismatches;

        function void span(t_cp first, t_cp past, t_sel pick, t_cp amount);
            fold_rule_t r;
            r.first    = first;
            r.past     = past;
            r.pick     = pick;
            r.absolute = 1'b0;
            r.amount   = amount;
            rules.push_back(r);
        endfunction

        function void point(t_cp cp, t_cp target);
            fold_rule_t r;
            r.first    = cp;
            r.past     = cp + 21'h1;
            r.pick     = SEL_ALL;
            r.absolute = 1'b1;
            r.amount   = target;
            rules.push_back(r);
        endfunction

        function new();
            mismatches = 0;
            span(21'h00041, 21'h0005B, SEL_ALL,  21'h20);
            span(21'h000C0, 21'h000DF, SEL_ALL,  21'h20);
            point(21'h00178, 21'h000FF);
            span(21'h00100, 21'h00130, SEL_EVEN, 21'h1);
            point(21'h00130, 21'h00069);
            span(21'h00132, 21'h00138, SEL_EVEN, 21'h1);
            span(21'h00139, 21'h00149, SEL_ODD,  21'h1);
            span(21'h0014A, 21'h00178, SEL_EVEN, 21'h1);
            span(21'h00179, 21'h0017F, SEL_ODD,  21'h1);
            span(21'h00182, 21'h00186, SEL_EVEN, 21'h1);
            span(21'h00187, 21'h00188, SEL_ALL,  21'h1);
            span(21'h0018B, 21'h0018C, SEL_ALL,  21'h1);
            span(21'h00191, 21'h00192, SEL_ALL,  21'h1);
            span(21'h00198, 21'h00199, SEL_ALL,  21'h1);
            span(21'h001A0, 21'h001A6, SEL_ODD,  21'h1);
            span(21'h001A7, 21'h001A8, SEL_ALL,  21'h1);
            span(21'h001AC, 21'h001AD, SEL_ALL,  21'h1);
            span(21'h001AF, 21'h001B0, SEL_ALL,  21'h1);
            span(21'h001B3, 21'h001B4, SEL_ALL,  21'h1);
            span(21'h001B5, 21'h001B6, SEL_ALL,  21'h1);
            span(21'h001B8, 21'h001B9, SEL_ALL,  21'h1);
            span(21'h001BC, 21'h001BD, SEL_ALL,  21'h1);
            span(21'h001C5, 21'h001C6, SEL_ALL,  21'h1);
            span(21'h001C8, 21'h001C9, SEL_ALL,  21'h1);
            span(21'h001CB, 21'h001CC, SEL_ALL,  21'h1);
            span(21'h001CD, 21'h001DD, SEL_ODD,  21'h1);
            span(21'h001DE, 21'h001F0, SEL_EVEN, 21'h1);
            point(21'h001F1, 21'h001F3);
            span(21'h001F4, 21'h001F5, SEL_ALL,  21'h1);
            span(21'h001F8, 21'h00220, SEL_EVEN, 21'h1);
            point(21'h00181, 21'h00253);
            point(21'h00186, 21'h00254);
            point(21'h0018A, 21'h00257);
            point(21'h0018E, 21'h00258);
            point(21'h0018F, 21'h00259);
            point(21'h00190, 21'h0025B);
            point(21'h00193, 21'h00260);
            point(21'h00194, 21'h00263);
            point(21'h00197, 21'h00268);
            point(21'h00196, 21'h00269);
            point(21'h0019C, 21'h0026F);
            point(21'h0019D, 21'h00272);
            point(21'h0019F, 21'h00275);
            point(21'h001A9, 21'h00283);
            point(21'h001AE, 21'h00288);
            point(21'h001B1, 21'h0028A);
            point(21'h001B2, 21'h0028B);
            point(21'h001B7, 21'h00292);
            point(21'h00386, 21'h003AC);
            point(21'h00388, 21'h003AD);
            point(21'h00389, 21'h003AE);
            point(21'h0038A, 21'h003AF);
            point(21'h0038C, 21'h003CC);
            point(21'h0038E, 21'h003CD);
            point(21'h0038F, 21'h003CE);
            span(21'h00391, 21'h003AC, SEL_ALL,  21'h20);
            span(21'h003E2, 21'h003F0, SEL_EVEN, 21'h1);
            span(21'h00400, 21'h00410, SEL_ALL,  21'h50);
            span(21'h00410, 21'h00430, SEL_ALL,  21'h20);
            span(21'h00460, 21'h00482, SEL_EVEN, 21'h1);
            span(21'h0048A, 21'h004C0, SEL_EVEN, 21'h1);
            span(21'h004C1, 21'h004CF, SEL_ODD,  21'h1);
            point(21'h004C0, 21'h004CF);
            span(21'h004D0, 21'h00530, SEL_EVEN, 21'h1);
            span(21'h00531, 21'h00557, SEL_ALL,  21'h30);
            span(21'h010A0, 21'h010D0, SEL_ALL,  21'h30);
            span(21'h01E00, 21'h01E96, SEL_EVEN, 21'h1);
            span(21'h01EA0, 21'h01F00, SEL_EVEN, 21'h1);
            // greek extended: minus 8 when bit 3 is set
            span(21'h01F00, 21'h02000, SEL_BIT3, 21'h1FFFF8);
            span(21'h02160, 21'h02170, SEL_ALL,  21'h10);
            span(21'h024B6, 21'h024D0, SEL_ALL,  21'h1A);
            span(21'h02C00, 21'h02C30, SEL_ALL,  21'h30);
            span(21'h02C60, 21'h02C61, SEL_ALL,  21'h1);
            span(21'h02C67, 21'h02C68, SEL_ALL,  21'h1);
            span(21'h02C69, 21'h02C6A, SEL_ALL,  21'h1);
            span(21'h02C6B, 21'h02C6C, SEL_ALL,  21'h1);
            span(21'h02C72, 21'h02C73, SEL_ALL,  21'h1);
            span(21'h02C75, 21'h02C76, SEL_ALL,  21'h1);
            span(21'h02C80, 21'h02CE4, SEL_EVEN, 21'h1);
            span(21'h02CEB, 21'h02CEC, SEL_ALL,  21'h1);
            span(21'h02CED, 21'h02CEE, SEL_ALL,  21'h1);
            span(21'h02CF2, 21'h02CF3, SEL_ALL,  21'h1);
            span(21'h0A640, 21'h0A66E, SEL_EVEN, 21'h1);
            span(21'h0A680, 21'h0A69C, SEL_EVEN, 21'h1);
            span(21'h0A722, 21'h0A730, SEL_EVEN, 21'h1);
            span(21'h0A732, 21'h0A770, SEL_EVEN, 21'h1);
            span(21'h0A779, 21'h0A77D, SEL_ODD,  21'h1);
            span(21'h0A780, 21'h0A788, SEL_EVEN, 21'h1);
            span(21'h0A790, 21'h0A794, SEL_EVEN, 21'h1);
            span(21'h0A79A, 21'h0A7AA, SEL_EVEN, 21'h1);
            span(21'h0A7B6, 21'h0A7C4, SEL_EVEN, 21'h1);
            span(21'h0A7C7, 21'h0A7CB, SEL_EVEN, 21'h1);
            span(21'h0FF21, 21'h0FF3B, SEL_ALL,  21'h20);
            span(21'h10400, 21'h10428, SEL_ALL,  21'h28);
            span(21'h104B0, 21'h104D8, SEL_ALL,  21'h28);
            span(21'h1D400, 21'h1D41A, SEL_ALL,  21'h1A);
            span(21'h1D434, 21'h1D44E, SEL_ALL,  21'h1A);
            span(21'h1D468, 21'h1D482, SEL_ALL,  21'h1A);
            span(21'h1D49C, 21'h1D4B6, SEL_ALL,  21'h1A);
            span(21'h1D4D0, 21'h1D4EA, SEL_ALL,  21'h1A);
            span(21'h1D504, 21'h1D51E, SEL_ALL,  21'h1A);
            span(21'h1D538, 21'h1D552, SEL_ALL,  21'h1A);
            span(21'h1D56C, 21'h1D586, SEL_ALL,  21'h1A);
            span(21'h1D5A0, 21'h1D5BA, SEL_ALL,  21'h1A);
            span(21'h1D5D4, 21'h1D5EE, SEL_ALL,  21'h1A);
            span(21'h1D608, 21'h1D622, SEL_ALL,  21'h1A);
            span(21'h1D63C, 21'h1D656, SEL_ALL,  21'h1A);
            span(21'h1D670, 21'h1D68A, SEL_ALL,  21'h1A);
            span(21'h1D6A8, 21'h1D6C1, SEL_ALL,  21'h1A);
            span(21'h1D6E2, 21'h1D6FB, SEL_ALL,  21'h1A);
            span(21'h1D71C, 21'h1D735, SEL_ALL,  21'h1A);
            span(21'h1D756, 21'h1D76F, SEL_ALL,  21'h1A);
            span(21'h1D790, 21'h1D7A9, SEL_ALL,  21'h1A);
        endfunction

        // first matching rule in list order decides
        function t_cp lower_of(t_cp cp);
            bit hit;
            foreach (rules[i]) begin
                if (cp >= rules[i].first && cp < rules[i].past) begin
                    case (rules[i].pick)
                        SEL_EVEN: hit = !cp[0];
                        SEL_ODD:  hit = cp[0];
                        SEL_BIT3: hit = cp[3];
                        default:  hit = 1'b1;
                    endcase
                    if (hit) begin
                        return rules[i].absolute ? rules[i].amount
                                                 : t_cp'(cp + rules[i].amount);
                    end
                end
            end
            return cp;
        endfunction

        function void note_code(t_cp cp);
            expected_lower.push_back(lower_of(cp));
        endfunction

        function void report_mismatch(string what, t_cp want, t_cp got);
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
                $display("%t mismatch (%s): lower_code_point expected %06h got %06h",
                         $realtime, what, want, got);
            end
        endfunction

        function void check_lower(t_cp got);
            t_cp want;
            if (expected_lower.size() == 0) begin
                report_mismatch("no transaction pending", 'x, got);
            end else begin
                want = expected_lower.pop_front();
                if (got !== want) report_mismatch("wrong value", want, got);
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n      = 1'b0;
    logic        start        = 1'b0;
    t_cp         i_code_point = '0;
    logic        busy;
    logic        o_done;
    t_cp         o_lower_code_point;

    lowercase_scoreboard sb;
    int unsigned         cycle_count = 0;
    int unsigned         burst_left  = 0;

    t_cp directed_codes[] = '{
        21'h000000, 21'h1FFFFF, 21'h10FFFF, 21'h110000, 21'h000040, 21'h000041,
        21'h00005A, 21'h00005B, 21'h0000C0, 21'h0000D7, 21'h0000DE, 21'h0000DF,
        21'h000178, 21'h000130, 21'h0001F1, 21'h0004C0, 21'h001F00, 21'h001F08,
        21'h001FFF, 21'h002160, 21'h0024B6, 21'h002C00, 21'h002C80, 21'h002C81,
        21'h002CE3
    };

    unicode_to_lowercase dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .start              (start),
        .busy               (busy),
        .i_code_point       (i_code_point),
        .o_done             (o_done),
        .o_lower_code_point (o_lower_code_point)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_done !== 1'b0) sb.check_lower(o_lower_code_point);
    end

    // mostly at rule edges or inside rule ranges, some below 21'h10000, the rest anywhere in the 21-bit space
    function automatic t_cp random_code();
        fold_rule_t  r;
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 20) return t_cp'($urandom);
        if (roll < 30) return t_cp'($urandom_range(0, 32'hFFFF));
        r = sb.rules[$urandom_range(0, sb.rules.size() - 1)];
        case ($urandom_range(0, 5))
            0:       return t_cp'(r.first - 1);
            1:       return r.first;
            2:       return t_cp'(r.past - 1);
            3:       return r.past;
            default: return t_cp'($urandom_range(r.first, r.past - 1));
        endcase
    endfunction

    task automatic send_code(input t_cp cp);
        int unsigned idle_len;
        start        <= 1'b1;
        i_code_point <= cp;
        @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
        sb.note_code(cp);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                    : $urandom_range(0, 12);
            idle_len   = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 30)
                                                    : $urandom_range(1, 5);
            // idle cycles carry junk on the data port
            start <= 1'b0;
            repeat (idle_len) begin
                i_code_point <= t_cp'($urandom);
                @(posedge i_clk);
            end
        end
    endtask

    initial begin
        int unsigned drain_cycles;
        sb = new();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        foreach (directed_codes[k]) send_code(directed_codes[k]);
        repeat (RANDOM_CODES) send_code(random_code());
        start <= 1'b0;
        drain_cycles = 0;
        while (sb.expected_lower.size() != 0 && drain_cycles < DRAIN_LIMIT) begin
            @(posedge i_clk);
            drain_cycles++;
        end
        repeat (10) @(posedge i_clk);
        if (sb.expected_lower.size() != 0) begin
            $display("results missing: %0d", sb.expected_lower.size());
        end
        if (sb.mismatches == 0 && sb.expected_lower.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
